[rtl/slsa_pkg.sv]
// ----------------------------------------------------------------------------
// slsa_pkg
// Types shared by the shadow slot allocator: sequencer states and the
// per-slot compare result.
// ----------------------------------------------------------------------------
package slsa_pkg;

  // Field widths of the streams
  localparam int unsigned LightW = 64;
  localparam int unsigned FrameW = 64;
  localparam int unsigned SlotW  = 6;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  // Verdict of the compare unit for one slot
  typedef struct packed {
    logic keep;    // owned by this light, used in the previous frame
    logic claim;   // empty, or owned by this light
    logic better;  // last-used frame below the best seen so far
  } cmp_res_t;

endpackage

[rtl/slsa_cmp.sv]
// ----------------------------------------------------------------------------
// slsa_cmp
// Shared compare unit: checks one slot against the current request.
// ----------------------------------------------------------------------------
module slsa_cmp
  import slsa_pkg::*;
(
  input  logic              slot_valid,
  input  logic [LightW-1:0] slot_owner,
  input  logic [FrameW-1:0] slot_frame,
  input  logic [LightW-1:0] light_id,
  input  logic [FrameW-1:0] prev_frame,
  input  logic [FrameW-1:0] best_frame,
  output cmp_res_t          res
);

  logic mine;

  // Owner match, previous-frame match and LRU compare
  always_comb begin
    mine       = slot_valid && (slot_owner == light_id);
    res.keep   = mine && (slot_frame == prev_frame);
    res.claim  = mine || !slot_valid;
    res.better = slot_frame < best_frame;
  end

endmodule

[rtl/shadow_layer_slot_allocator.sv]
// ----------------------------------------------------------------------------
// shadow_layer_slot_allocator
// LRU allocator of shadow slots, one slot checked per cycle.
// ----------------------------------------------------------------------------
// A request (light id, frame number) is taken when in_tready is high; the
// block then walks the slot table one slot a cycle through a single compare
// unit and stops at the first slot that is empty or already owned by the
// light; the result notes whether the light held that slot in the previous
// frame. If the walk reaches the end, the least recently used slot not
// touched this frame is taken. The slots are checked one per cycle and the
// result is registered on the last. The next request is taken only once the
// result has been transferred out, so the block does not take a new request
// while the last one is still being scanned or held for output.
// ----------------------------------------------------------------------------
module shadow_layer_slot_allocator
  import slsa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] light_id, [127:64] frame_number
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata   // [0] found, [6:1] slot_index, [7] reject_history
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Slot table
  logic [LightW-1:0] owner_r [NUM_SLOTS];
  logic [FrameW-1:0] frame_tab_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;

  // Request and scan registers
  state_t state_r, state_nxt;
  logic [LightW-1:0] light_r;
  logic [FrameW-1:0] frame_r, prev_r;
  logic [FrameW-1:0] best_frame_r, best_frame_nxt;
  logic [IdxW-1:0]   best_idx_r, best_idx_nxt;
  logic              have_best_r, have_best_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  cmp_res_t cmp;
  logic     in_xfer, out_xfer, hit, last_slot, done;
  logic     claim_en;
  logic [IdxW-1:0] claim_idx;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign hit       = cmp.keep || cmp.claim;
  assign last_slot = (idx_r == IdxW'(NUM_SLOTS - 1));
  assign done      = (state_r == S_SCAN) && (hit || last_slot);

  // Compare unit on the slot under the scan pointer
  slsa_cmp u_cmp (
    .slot_valid (valid_r[idx_r]),
    .slot_owner (owner_r[idx_r]),
    .slot_frame (frame_tab_r[idx_r]),
    .light_id   (light_r),
    .prev_frame (prev_r),
    .best_frame (best_frame_r),
    .res        (cmp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_SCAN;
      S_SCAN: if (done) state_nxt = S_OUT;
      S_OUT:  if (out_xfer) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_SCAN: ;
      S_OUT:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = out_data_r;

  // LRU tracking, scan pointer and result
  always_comb begin
    best_frame_nxt = best_frame_r;
    best_idx_nxt   = best_idx_r;
    have_best_nxt  = have_best_r;
    idx_nxt        = idx_r;
    out_data_nxt   = out_data_r;
    claim_en       = 1'b0;
    claim_idx      = idx_r;
    if (in_xfer) begin
      best_frame_nxt = in_tdata[127:64];
      best_idx_nxt   = '0;
      have_best_nxt  = 1'b0;
      idx_nxt        = '0;
    end else if (state_r == S_SCAN) begin
      if (hit) begin
        claim_en     = 1'b1;
        out_data_nxt = {!cmp.keep, SlotW'(idx_r), 1'b1};
      end else begin
        if (cmp.better) begin
          best_frame_nxt = frame_tab_r[idx_r];
          best_idx_nxt   = idx_r;
          have_best_nxt  = 1'b1;
        end
        if (last_slot) begin
          claim_en  = have_best_nxt;
          claim_idx = best_idx_nxt;
          out_data_nxt = have_best_nxt ? {1'b1, SlotW'(best_idx_nxt), 1'b1} : 8'd0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (claim_en) valid_r[claim_idx] <= 1'b1;
    end
  end

  // Payload and table registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      light_r <= in_tdata[63:0];
      frame_r <= in_tdata[127:64];
      prev_r  <= in_tdata[127:64] - 1'b1;
    end
    best_frame_r <= best_frame_nxt;
    best_idx_r   <= best_idx_nxt;
    have_best_r  <= have_best_nxt;
    idx_r        <= idx_nxt;
    out_data_r   <= out_data_nxt;
    if (claim_en) begin
      owner_r[claim_idx]     <= light_r;
      frame_tab_r[claim_idx] <= frame_r;
    end
  end

endmodule
